// ===== src/ohs_pkg.sv =====
// ============================================================================
// ohs_pkg
// Shared types and constants of the offboard handover supervisor.
// ============================================================================
`default_nettype none

package ohs_pkg;

    // Field widths.
    localparam int unsigned SETPOINT_W = 8;
    localparam int unsigned PRIMED_W   = 16;
    localparam int unsigned WINDOW_W   = 14;
    localparam int unsigned TICKS_W    = 6;
    localparam int unsigned ELAPSED_W  = 8;
    localparam int unsigned STATE_W    = 3;
    localparam int unsigned DETAIL_W   = 4;

    // Stream and configuration port widths.
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [PRIMED_W-1:0]  PRIMING_RST  = 16'd10;
    localparam logic [WINDOW_W-1:0]  MIN_COUNT_RST = 14'd2;
    localparam logic [TICKS_W-1:0]   WINDOW_RST   = 6'd5;
    localparam logic [ELAPSED_W-1:0] TIMEOUT_RST  = 8'd10;
    localparam logic                 AUTO_RST     = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PRIMING_SETPOINTS    = 3'd0,
        REG_MIN_WINDOW_COUNT     = 3'd1,
        REG_WINDOW_TICKS         = 3'd2,
        REG_ENGAGE_TIMEOUT_TICKS = 3'd3,
        REG_SELF_REQUEST         = 3'd4
    } cfg_index_t;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE      = 3'd0,
        ST_STREAMING = 3'd1,
        ST_ENGAGING  = 3'd2,
        ST_ACTIVE    = 3'd3,
        ST_FAULT     = 3'd4
    } session_state_t;

    typedef enum logic [DETAIL_W-1:0] {
        DT_WAITING        = 4'd0,
        DT_STREAM_FOUND   = 4'd1,
        DT_STREAM_STOPPED = 4'd2,
        DT_ALREADY_ACTIVE = 4'd3,
        DT_CONFIRMED      = 4'd4,
        DT_RETRY          = 4'd5,
        DT_AUTOPILOT_OWNS = 4'd6,
        DT_PILOT_OVERRIDE = 4'd7,
        DT_LEFT_OFFBOARD  = 4'd8,
        DT_RATE_LOW       = 4'd9,
        DT_FLIGHT_DONE    = 4'd10,
        DT_RECOVERED      = 4'd11,
        DT_REQUESTED      = 4'd12
    } detail_t;

    typedef struct packed {
        logic                 self_request_en;
        logic [ELAPSED_W-1:0] engage_timeout_ticks;
        logic [TICKS_W-1:0]   window_ticks;
        logic [WINDOW_W-1:0]  min_window_count;
        logic [PRIMED_W-1:0]  priming_setpoints;
    } cfg_t;

    typedef struct packed {
        logic                  pilot_override;
        logic                  autopilot_owns;
        logic                  mode_confirmed;
        logic [SETPOINT_W-1:0] setpoints_this_tick;
    } tick_in_t;

    typedef struct packed {
        logic                confirmed_echo;
        logic [WINDOW_W-1:0] measured_count;
        logic                stream_fresh;
        logic                request_offboard;
        detail_t             detail_code;
        session_state_t      session_state;
    } tick_out_t;

endpackage

`default_nettype wire

// ===== src/ohs_cfg_regs.sv =====
// ============================================================================
// ohs_cfg_regs
// Write-only configuration register bank of the handover supervisor.
// ============================================================================
`default_nettype none

module ohs_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [ohs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [ohs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ohs_pkg::cfg_t                         cfg
);

    ohs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.priming_setpoints    <= ohs_pkg::PRIMING_RST;
            cfg_reg.min_window_count     <= ohs_pkg::MIN_COUNT_RST;
            cfg_reg.window_ticks         <= ohs_pkg::WINDOW_RST;
            cfg_reg.engage_timeout_ticks <= ohs_pkg::TIMEOUT_RST;
            cfg_reg.self_request_en      <= ohs_pkg::AUTO_RST;
        end
        else if (cfg_we)
        begin
            unique case (ohs_pkg::cfg_index_t'(cfg_addr))
                ohs_pkg::REG_PRIMING_SETPOINTS:
                    cfg_reg.priming_setpoints <= cfg_wdata[ohs_pkg::PRIMED_W-1:0];
                ohs_pkg::REG_MIN_WINDOW_COUNT:
                    cfg_reg.min_window_count <= cfg_wdata[ohs_pkg::WINDOW_W-1:0];
                ohs_pkg::REG_WINDOW_TICKS:
                    cfg_reg.window_ticks <= cfg_wdata[ohs_pkg::TICKS_W-1:0];
                ohs_pkg::REG_ENGAGE_TIMEOUT_TICKS:
                    cfg_reg.engage_timeout_ticks <= cfg_wdata[ohs_pkg::ELAPSED_W-1:0];
                ohs_pkg::REG_SELF_REQUEST:
                    cfg_reg.self_request_en <= cfg_wdata[0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/ohs_core.sv =====
// ============================================================================
// ohs_core
// Per-tick counters and handover state machine; state advances on tick_en.
// ============================================================================
`default_nettype none

module ohs_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tick_en,
    input  wire ohs_pkg::tick_in_t  tick_in,
    input  wire ohs_pkg::cfg_t      cfg,
    output ohs_pkg::tick_out_t      tick_out
);

    ohs_pkg::session_state_t          state_reg, state_next;
    ohs_pkg::detail_t                 detail_reg, detail_next;
    logic [ohs_pkg::PRIMED_W-1:0]     primed_reg, primed_next;
    logic [ohs_pkg::WINDOW_W-1:0]     window_reg, window_next;
    logic [ohs_pkg::TICKS_W-1:0]      ticks_reg, ticks_next;
    logic [ohs_pkg::WINDOW_W-1:0]     measured_reg, measured_next;
    logic [ohs_pkg::ELAPSED_W-1:0]    elapsed_reg, elapsed_next;

    logic [ohs_pkg::PRIMED_W:0]       primed_sum;
    logic [ohs_pkg::PRIMED_W-1:0]     primed_acc;
    logic [ohs_pkg::WINDOW_W:0]       window_sum;
    logic [ohs_pkg::WINDOW_W-1:0]     window_acc;
    logic [ohs_pkg::TICKS_W-1:0]      ticks_inc;
    logic [ohs_pkg::TICKS_W-1:0]      limit;
    logic                             window_close;
    logic                             fresh;
    logic                             confirmed;
    logic                             owns;
    logic                             override_on;
    logic                             primed_ok;
    logic                             timed_out;
    logic                             request;

    assign confirmed   = tick_in.mode_confirmed;
    assign owns        = tick_in.autopilot_owns;
    assign override_on = tick_in.pilot_override;

    // Saturating accumulation of setpoints into priming and window counts.
    assign primed_sum = {1'b0, primed_reg} +
                        {{(ohs_pkg::PRIMED_W + 1 - ohs_pkg::SETPOINT_W){1'b0}},
                         tick_in.setpoints_this_tick};
    assign primed_acc = primed_sum[ohs_pkg::PRIMED_W] ? '1
                                                      : primed_sum[ohs_pkg::PRIMED_W-1:0];
    assign window_sum = {1'b0, window_reg} +
                        {{(ohs_pkg::WINDOW_W + 1 - ohs_pkg::SETPOINT_W){1'b0}},
                         tick_in.setpoints_this_tick};
    assign window_acc = window_sum[ohs_pkg::WINDOW_W] ? '1
                                                      : window_sum[ohs_pkg::WINDOW_W-1:0];

    // A window length of zero behaves as one tick.
    assign ticks_inc    = (&ticks_reg) ? ticks_reg : ticks_reg + 1'b1;
    assign limit        = (cfg.window_ticks == '0) ? {{(ohs_pkg::TICKS_W-1){1'b0}}, 1'b1}
                                                   : cfg.window_ticks;
    assign window_close = (ticks_inc >= limit);

    assign window_next   = window_close ? '0 : window_acc;
    assign ticks_next    = window_close ? '0 : ticks_inc;
    assign measured_next = window_close ? window_acc : measured_reg;
    assign fresh         = (measured_next >= cfg.min_window_count);

    assign primed_ok = (primed_acc >= cfg.priming_setpoints);
    assign timed_out = (elapsed_reg >= cfg.engage_timeout_ticks);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ohs_pkg::ST_IDLE:
            begin
                if (fresh)
                    state_next = ohs_pkg::ST_STREAMING;
            end
            ohs_pkg::ST_STREAMING:
            begin
                if (!fresh)
                    state_next = ohs_pkg::ST_IDLE;
                else if (confirmed)
                    state_next = ohs_pkg::ST_ACTIVE;
                else if (cfg.self_request_en && !owns && !override_on && primed_ok)
                    state_next = ohs_pkg::ST_ENGAGING;
            end
            ohs_pkg::ST_ENGAGING:
            begin
                if (confirmed)
                    state_next = ohs_pkg::ST_ACTIVE;
                else if (timed_out)
                    state_next = ohs_pkg::ST_STREAMING;
            end
            ohs_pkg::ST_ACTIVE:
            begin
                if (!confirmed)
                    state_next = (owns || override_on) ? ohs_pkg::ST_STREAMING
                                                       : ohs_pkg::ST_FAULT;
                else if (!fresh)
                    state_next = ohs_pkg::ST_FAULT;
            end
            ohs_pkg::ST_FAULT:
            begin
                if (!fresh)
                    state_next = ohs_pkg::ST_IDLE;
                else if (confirmed)
                    state_next = ohs_pkg::ST_ACTIVE;
            end
            default:
                state_next = state_reg;
        endcase
    end

    // Detail code, request pulse, priming clear and engage timer.
    always_comb
    begin
        detail_next  = detail_reg;
        primed_next  = primed_acc;
        elapsed_next = elapsed_reg;
        request      = 1'b0;
        unique case (state_reg)
            ohs_pkg::ST_IDLE:
            begin
                if (fresh)
                    detail_next = ohs_pkg::DT_STREAM_FOUND;
            end
            ohs_pkg::ST_STREAMING:
            begin
                if (!fresh)
                begin
                    detail_next = ohs_pkg::DT_STREAM_STOPPED;
                    primed_next = '0;
                end
                else if (confirmed)
                    detail_next = ohs_pkg::DT_ALREADY_ACTIVE;
                else if (cfg.self_request_en && !owns && !override_on && primed_ok)
                begin
                    detail_next  = ohs_pkg::DT_REQUESTED;
                    elapsed_next = '0;
                    request      = 1'b1;
                end
            end
            ohs_pkg::ST_ENGAGING:
            begin
                if (confirmed)
                    detail_next = ohs_pkg::DT_CONFIRMED;
                else if (timed_out)
                    detail_next = ohs_pkg::DT_RETRY;
                else if (!(&elapsed_reg))
                    elapsed_next = elapsed_reg + 1'b1;
            end
            ohs_pkg::ST_ACTIVE:
            begin
                if (!confirmed)
                begin
                    primed_next = '0;
                    if (owns)
                        detail_next = ohs_pkg::DT_AUTOPILOT_OWNS;
                    else if (override_on)
                        detail_next = ohs_pkg::DT_PILOT_OVERRIDE;
                    else
                        detail_next = ohs_pkg::DT_LEFT_OFFBOARD;
                end
                else if (!fresh)
                begin
                    primed_next = '0;
                    detail_next = ohs_pkg::DT_RATE_LOW;
                end
            end
            ohs_pkg::ST_FAULT:
            begin
                if (!fresh)
                begin
                    primed_next = '0;
                    detail_next = ohs_pkg::DT_FLIGHT_DONE;
                end
                else if (confirmed)
                    detail_next = ohs_pkg::DT_RECOVERED;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ohs_pkg::ST_IDLE;
            detail_reg   <= ohs_pkg::DT_WAITING;
            primed_reg   <= '0;
            window_reg   <= '0;
            ticks_reg    <= '0;
            measured_reg <= '0;
            elapsed_reg  <= '0;
        end
        else if (tick_en)
        begin
            state_reg    <= state_next;
            detail_reg   <= detail_next;
            primed_reg   <= primed_next;
            window_reg   <= window_next;
            ticks_reg    <= ticks_next;
            measured_reg <= measured_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    always_comb
    begin
        tick_out.session_state    = state_next;
        tick_out.detail_code      = detail_next;
        tick_out.request_offboard = request;
        tick_out.stream_fresh     = fresh;
        tick_out.measured_count   = measured_next;
        tick_out.confirmed_echo   = confirmed;
    end

endmodule

`default_nettype wire

// ===== src/offboard_handover_supervisor_top.sv =====
// ============================================================================
// offboard_handover_supervisor_top
// Supervises handover of flight control to an offboard setpoint stream.
// ============================================================================
//
//   Port group   Direction  Payload
//   -----------  ---------  -----------------------------------------------
//   s_axis_*     in         one supervision tick (counts and flags)
//   m_axis_*     out        one status result per tick
//   cfg_*        in         register writes, index 0..4, no read-back
//
// Each tick is captured in an input register; once the output register
// can take it, the counter and state machine logic evaluate it and the
// result lands in the output register, which offers it on m_axis. One
// tick is accepted every clock cycle while m_axis is ready. The sustained
// rate is set by the single state update per cycle in the core. When the
// output register is full and not taken, the input register holds its tick
// and s_axis_tready drops once both are occupied; nothing is lost or
// repeated. An asynchronous active-low reset returns the machine to idle
// with all counters cleared and the configuration registers at defaults.
// ============================================================================
`default_nettype none

module offboard_handover_supervisor_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // tdata: setpoints_this_tick[7:0], mode_confirmed[8],
    //        autopilot_owns[9], pilot_override[10], zero fill [15:11]
    input  wire logic [ohs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: session_state[2:0], detail_code[6:3], request_offboard[7],
    //        stream_fresh[8], measured_count[22:9], confirmed_echo[23]
    output logic [ohs_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              cfg_we,
    input  wire logic [ohs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [ohs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    ohs_pkg::cfg_t      cfg;
    ohs_pkg::tick_in_t  in_data_reg;
    logic               in_valid_reg;
    ohs_pkg::tick_out_t result;
    ohs_pkg::tick_out_t out_data_reg;
    logic               out_valid_reg;
    logic               fire;
    logic               in_take;

    // The core evaluates a tick whenever the output register can take it.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    ohs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ohs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_en  (fire),
        .tick_in  (in_data_reg),
        .cfg      (cfg),
        .tick_out (result)
    );

    // Input register: control state is reset, payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= ohs_pkg::tick_in_t'(s_axis_tdata[10:0]);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A request pulse only ever accompanies the move into the engaging state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.request_offboard |->
            out_data_reg.session_state == ohs_pkg::ST_ENGAGING &&
            out_data_reg.detail_code == ohs_pkg::DT_REQUESTED)
        else $error("request without engaging transition");

    // Freshness reported must agree with the measured count and threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            out_data_reg.stream_fresh ==
            (out_data_reg.measured_count >= cfg.min_window_count))
        else $error("freshness inconsistent with measured count");

    // Remaining in or entering the active state requires confirmation.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.session_state == ohs_pkg::ST_ACTIVE |->
            out_data_reg.confirmed_echo)
        else $error("active state without confirmation");

    // A stalled tick in the input register is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("pending tick lost");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ============================================================================
// tb
// Self-checking testbench for the offboard handover supervisor.
// ============================================================================
//
// Supervision ticks go in on the s_axis stream and status results come back
// on m_axis. Every tick produces exactly one result. The bench keeps its own
// model of the supervisor: counters, the rate window and the five-state
// handover machine. Each accepted tick advances that model and queues the
// status it should produce. A checker process pops that queue on every
// accepted result and compares all six fields.
//
// A short directed walk covers the reset defaults and every transition of
// the machine. Several random phases follow, each under its own register
// setting and its own mix of sender gaps and receiver back-pressure. The
// random ticks are steered by the model's current state, so that the stream
// mostly stays fresh and confirmations arrive in a plausible order. This
// lets the machine reach its deep states: engaging, long timeouts, active
// and fault.
// ============================================================================

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ohs_pkg::*;

    // Writes to this index must be ignored by the block.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    // Generous bound on the whole run, in nanoseconds.
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;
    // Bound on the wait for outstanding results at each drain point.
    localparam int unsigned DRAIN_LIMIT  = 5000;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports.
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n         = 1'b0;

    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    offboard_handover_supervisor_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the supervisor: register copies and machine state.
    // ------------------------------------------------------------------------
    logic [PRIMED_W-1:0]  cfg_priming;
    logic [WINDOW_W-1:0]  cfg_min_count;
    logic [TICKS_W-1:0]   cfg_window;
    logic [ELAPSED_W-1:0] cfg_timeout;
    logic                 cfg_auto;

    session_state_t       model_state;
    detail_t              model_detail;
    logic [PRIMED_W-1:0]  primed_total;
    logic [WINDOW_W-1:0]  window_sum;
    logic [TICKS_W-1:0]   window_ticks_seen;
    logic [WINDOW_W-1:0]  last_window;
    logic [ELAPSED_W-1:0] engage_wait;

    // Status words still owed by the block, oldest first.
    tick_out_t            expected_status[$];

    // Sender gap and receiver stall rates, in percent.
    int unsigned          idle_pct  = 0;
    int unsigned          stall_pct = 0;

    // Steering of the random ticks. The floor is the least setpoint count of
    // a healthy tick. Stray is the chance of an unrequested confirmation,
    // grant the chance per engaging tick that the autopilot confirms, and
    // upset the chance of a fully random tick that may start a dropout.
    int unsigned          knob_floor;
    int unsigned          knob_stray;
    int unsigned          knob_grant;
    int unsigned          knob_upset;
    int unsigned          dropout_left = 0;

    int unsigned          error_count     = 0;
    int unsigned          ticks_checked   = 0;
    int unsigned          requests_issued = 0;
    int unsigned          retries_seen    = 0;
    int unsigned          faults_entered  = 0;

    task automatic reset_model();
        cfg_priming       = PRIMING_RST;
        cfg_min_count     = MIN_COUNT_RST;
        cfg_window        = WINDOW_RST;
        cfg_timeout       = TIMEOUT_RST;
        cfg_auto          = AUTO_RST;
        model_state       = ST_IDLE;
        model_detail      = DT_WAITING;
        primed_total      = '0;
        window_sum        = '0;
        window_ticks_seen = '0;
        last_window       = '0;
        engage_wait       = '0;
    endtask

    // Advances the model by one supervision tick and returns the status the
    // block must report for it. All counters saturate at all ones.
    function automatic tick_out_t supervise_tick(input tick_in_t t);
        tick_out_t   r;
        int unsigned sum;
        int unsigned span;
        logic        fresh;
        logic        req;

        req = 1'b0;
        sum = primed_total + t.setpoints_this_tick;
        primed_total = (sum > 16'hFFFF) ? '1 : sum[PRIMED_W-1:0];
        sum = window_sum + t.setpoints_this_tick;
        window_sum = (sum > 14'h3FFF) ? '1 : sum[WINDOW_W-1:0];
        sum = window_ticks_seen + 1;
        window_ticks_seen = (sum > 6'h3F) ? '1 : sum[TICKS_W-1:0];

        // A window length of zero behaves like one.
        span = (cfg_window == 0) ? 1 : cfg_window;
        if (window_ticks_seen >= span)
        begin
            last_window       = window_sum;
            window_sum        = '0;
            window_ticks_seen = '0;
        end
        fresh = (last_window >= cfg_min_count);

        case (model_state)
            ST_IDLE:
            begin
                if (fresh)
                begin
                    model_state  = ST_STREAMING;
                    model_detail = DT_STREAM_FOUND;
                end
            end
            ST_STREAMING:
            begin
                if (!fresh)
                begin
                    model_state  = ST_IDLE;
                    primed_total = '0;
                    model_detail = DT_STREAM_STOPPED;
                end
                else if (t.mode_confirmed)
                begin
                    model_state  = ST_ACTIVE;
                    model_detail = DT_ALREADY_ACTIVE;
                end
                else if (cfg_auto && !t.autopilot_owns && !t.pilot_override &&
                         primed_total >= cfg_priming)
                begin
                    req          = 1'b1;
                    engage_wait  = '0;
                    model_state  = ST_ENGAGING;
                    model_detail = DT_REQUESTED;
                    requests_issued++;
                end
            end
            ST_ENGAGING:
            begin
                // Freshness is deliberately not looked at while engaging.
                if (t.mode_confirmed)
                begin
                    model_state  = ST_ACTIVE;
                    model_detail = DT_CONFIRMED;
                end
                else if (engage_wait >= cfg_timeout)
                begin
                    model_state  = ST_STREAMING;
                    model_detail = DT_RETRY;
                    retries_seen++;
                end
                else if (engage_wait != '1)
                begin
                    engage_wait = engage_wait + 1'b1;
                end
            end
            ST_ACTIVE:
            begin
                if (!t.mode_confirmed)
                begin
                    primed_total = '0;
                    if (t.autopilot_owns)
                    begin
                        model_state  = ST_STREAMING;
                        model_detail = DT_AUTOPILOT_OWNS;
                    end
                    else if (t.pilot_override)
                    begin
                        model_state  = ST_STREAMING;
                        model_detail = DT_PILOT_OVERRIDE;
                    end
                    else
                    begin
                        model_state  = ST_FAULT;
                        model_detail = DT_LEFT_OFFBOARD;
                        faults_entered++;
                    end
                end
                else if (!fresh)
                begin
                    model_state  = ST_FAULT;
                    primed_total = '0;
                    model_detail = DT_RATE_LOW;
                    faults_entered++;
                end
            end
            ST_FAULT:
            begin
                if (!fresh)
                begin
                    model_state  = ST_IDLE;
                    primed_total = '0;
                    model_detail = DT_FLIGHT_DONE;
                end
                else if (t.mode_confirmed)
                begin
                    model_state  = ST_ACTIVE;
                    model_detail = DT_RECOVERED;
                end
            end
            default:
            begin
            end
        endcase

        r.session_state    = model_state;
        r.detail_code      = model_detail;
        r.request_offboard = req;
        r.stream_fresh     = fresh;
        r.measured_count   = last_window;
        r.confirmed_echo   = t.mode_confirmed;
        return r;
    endfunction

    function automatic tick_in_t tick_of(input int unsigned sp, input logic confirmed,
                                         input logic owns, input logic pilot);
        tick_in_t t;

        t.setpoints_this_tick = sp[SETPOINT_W-1:0];
        t.mode_confirmed      = confirmed;
        t.autopilot_owns      = owns;
        t.pilot_override      = pilot;
        return t;
    endfunction

    // Picks the next random tick. Most ticks keep the stream healthy enough
    // to stay fresh, and the confirmation flag follows what the machine is
    // waiting for. The rest are raw noise or short dropouts of the stream.
    function automatic tick_in_t pick_tick();
        tick_in_t    t;
        logic [31:0] r;
        int unsigned span;
        int unsigned lo;
        int unsigned pct;

        r = $urandom;
        t = r[$bits(tick_in_t)-1:0];
        if ($urandom_range(0, 99) < knob_upset)
        begin
            if ($urandom_range(0, 3) == 0)
                dropout_left = $urandom_range(1, 8);
            return t;
        end

        // Least per-tick count that keeps a whole window at the minimum.
        span = (cfg_window == 0) ? 1 : cfg_window;
        lo = (cfg_min_count + span - 1) / span;
        if (lo < knob_floor)
            lo = knob_floor;
        if (lo > 255)
            lo = 255;

        if (dropout_left != 0)
        begin
            dropout_left--;
            t.setpoints_this_tick = (lo == 0) ? 8'd0 : 8'($urandom_range(0, lo - 1));
        end
        else
        begin
            t.setpoints_this_tick = 8'($urandom_range(lo, 255));
        end

        case (model_state)
            ST_ENGAGING: pct = knob_grant;
            ST_ACTIVE:   pct = 95;
            ST_FAULT:    pct = 40;
            default:     pct = knob_stray;
        endcase
        t.mode_confirmed = ($urandom_range(0, 99) < pct);
        t.autopilot_owns = ($urandom_range(0, 99) < 10);
        t.pilot_override = ($urandom_range(0, 99) < 10);
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting and the result checker.
    // ------------------------------------------------------------------------
    task automatic report_error(input string what);
        error_count++;
        $display("tb: mismatch at %0t ns: %s", $realtime, what);
    endtask

    // The receiver is ready at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Every transaction on m_axis is checked against the oldest owed status.
    always @(posedge clk)
    begin : check_status
        tick_out_t got;
        tick_out_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_status.size() == 0)
            begin
                report_error($sformatf("status %h with no tick pending", m_axis_tdata));
            end
            else
            begin
                want = expected_status.pop_front();
                ticks_checked++;
                if (got.session_state !== want.session_state)
                    report_error($sformatf("session_state %0d, expected %0d",
                                           got.session_state, want.session_state));
                if (got.detail_code !== want.detail_code)
                    report_error($sformatf("detail_code %0d, expected %0d",
                                           got.detail_code, want.detail_code));
                if (got.request_offboard !== want.request_offboard)
                    report_error($sformatf("request_offboard %b, expected %b",
                                           got.request_offboard, want.request_offboard));
                if (got.stream_fresh !== want.stream_fresh)
                    report_error($sformatf("stream_fresh %b, expected %b",
                                           got.stream_fresh, want.stream_fresh));
                if (got.measured_count !== want.measured_count)
                    report_error($sformatf("measured_count %0d, expected %0d",
                                           got.measured_count, want.measured_count));
                if (got.confirmed_echo !== want.confirmed_echo)
                    report_error($sformatf("confirmed_echo %b, expected %b",
                                           got.confirmed_echo, want.confirmed_echo));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one tick, with random sender gaps before it, and predicts its
    // status once the transaction completes. tvalid is left high so that
    // back-to-back ticks need no second assignment in the same step.
    task automatic send_tick(input tick_in_t t);
        tick_out_t want;

        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= IN_DATA_W'(t);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = supervise_tick(t);
        expected_status.push_back(want);
    endtask

    // Stops sending and waits until every owed status has come back. Whatever
    // is still owed after the bound is reported and dropped.
    task automatic drain_results();
        int unsigned waited;

        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_status.size() != 0)
        begin
            report_error($sformatf("%0d statuses never delivered", expected_status.size()));
            expected_status.delete();
        end
        @(posedge clk);
    endtask

    // Writes one register. The bits above the register's width carry random
    // junk, which the block has to ignore, and so does the model.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        logic [31:0]           r;
        logic [CFG_DATA_W-1:0] data;

        r    = $urandom;
        data = r[CFG_DATA_W-1:0];
        case (index)
            REG_PRIMING_SETPOINTS:
            begin
                data        = value;
                cfg_priming = data;
            end
            REG_MIN_WINDOW_COUNT:
            begin
                data[WINDOW_W-1:0] = value[WINDOW_W-1:0];
                cfg_min_count      = data[WINDOW_W-1:0];
            end
            REG_WINDOW_TICKS:
            begin
                data[TICKS_W-1:0] = value[TICKS_W-1:0];
                cfg_window        = data[TICKS_W-1:0];
            end
            REG_ENGAGE_TIMEOUT_TICKS:
            begin
                data[ELAPSED_W-1:0] = value[ELAPSED_W-1:0];
                cfg_timeout         = data[ELAPSED_W-1:0];
            end
            REG_SELF_REQUEST:
            begin
                data[0]  = value[0];
                cfg_auto = data[0];
            end
            default:
            begin
            end
        endcase
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Loads a full register setting once the block has gone quiet, then
    // pokes the unused index, which must change nothing.
    task automatic load_settings(input int unsigned priming, input int unsigned min_count,
                                 input int unsigned window, input int unsigned timeout,
                                 input int unsigned auto_on);
        drain_results();
        write_register(REG_PRIMING_SETPOINTS, priming[CFG_DATA_W-1:0]);
        write_register(REG_MIN_WINDOW_COUNT, min_count[CFG_DATA_W-1:0]);
        write_register(REG_WINDOW_TICKS, window[CFG_DATA_W-1:0]);
        write_register(REG_ENGAGE_TIMEOUT_TICKS, timeout[CFG_DATA_W-1:0]);
        write_register(REG_SELF_REQUEST, auto_on[CFG_DATA_W-1:0]);
        write_register(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // One random phase under the current setting. The phase ends with the
    // sender holding off until every status has arrived.
    task automatic run_phase(input int unsigned items, input int unsigned sender_idle,
                             input int unsigned receiver_stall, input int unsigned floor_sp,
                             input int unsigned stray, input int unsigned grant,
                             input int unsigned upset);
        idle_pct     = sender_idle;
        stall_pct    = receiver_stall;
        knob_floor   = floor_sp;
        knob_stray   = stray;
        knob_grant   = grant;
        knob_upset   = upset;
        dropout_left = 0;
        repeat (items)
            send_tick(pick_tick());
        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Registers at their reset values: a slow stream closes its first window
    // on the fifth tick and the machine leaves idle. Priming is not reached.
    task automatic test_reset_defaults();
        send_tick(tick_of(0, 1'b0, 1'b0, 1'b0));
        repeat (4)
            send_tick(tick_of(1, 1'b0, 1'b0, 1'b0));
    endtask

    // Window length zero, so every tick closes a window and the measured
    // count is just that tick's setpoints. This walks every transition,
    // including the retry after the timeout, engaging with no stream, and
    // requests held back by autopilot ownership and by pilot override.
    task automatic test_state_walk();
        load_settings(0, 1, 0, 2, 1);
        send_tick(tick_of(0,   1'b0, 1'b0, 1'b0));  // stream gone, back to idle
        send_tick(tick_of(255, 1'b1, 1'b1, 1'b1));  // all fields at their top
        send_tick(tick_of(5,   1'b1, 1'b0, 1'b0));  // confirmed while streaming
        send_tick(tick_of(0,   1'b1, 1'b0, 1'b0));  // rate drops while active
        send_tick(tick_of(5,   1'b1, 1'b0, 1'b0));  // recovered from fault
        send_tick(tick_of(5,   1'b0, 1'b1, 1'b0));  // autopilot takes over
        send_tick(tick_of(5,   1'b0, 1'b0, 1'b0));  // request issued
        send_tick(tick_of(5,   1'b0, 1'b0, 1'b0));  // waiting for confirmation
        send_tick(tick_of(0,   1'b0, 1'b0, 1'b0));  // still waiting, no stream
        send_tick(tick_of(0,   1'b0, 1'b0, 1'b0));  // timeout, retry
        send_tick(tick_of(0,   1'b0, 1'b0, 1'b0));  // stream stopped
        send_tick(tick_of(5,   1'b0, 1'b0, 1'b0));  // stream found
        send_tick(tick_of(5,   1'b0, 1'b0, 1'b0));  // request issued
        send_tick(tick_of(5,   1'b1, 1'b0, 1'b0));  // confirmed by autopilot
        send_tick(tick_of(5,   1'b0, 1'b0, 1'b1));  // pilot takes over
        send_tick(tick_of(5,   1'b0, 1'b1, 1'b0));  // request held back
        send_tick(tick_of(5,   1'b0, 1'b0, 1'b1));  // request held back
        send_tick(tick_of(5,   1'b1, 1'b0, 1'b0));  // already active
        send_tick(tick_of(5,   1'b0, 1'b0, 1'b0));  // left offboard unexpectedly
        send_tick(tick_of(0,   1'b0, 1'b0, 1'b0));  // flight over, back to idle
    endtask

    // Reset-value setting, steady traffic, no idling on either side.
    task automatic test_steady_stream();
        load_settings(10, 2, 5, 10, 1);
        run_phase(250, 0, 0, 0, 3, 25, 15);
    endtask

    // Every tick a window, any count fresh, no self-initiated requests.
    // The sender idles in most cycles.
    task automatic test_manual_engage();
        load_settings(0, 0, 1, 0, 0);
        run_phase(200, 70, 0, 0, 5, 50, 20);
    endtask

    // Minimum count beyond reach of the longest window: never fresh.
    // The receiver stalls in most cycles.
    task automatic test_unreachable_rate();
        load_settings(0, 16383, 63, 0, 1);
        run_phase(60, 0, 70, 0, 10, 50, 15);
    endtask

    // Priming at its top, so only a saturated counter permits a request, and
    // the longest timeout with no confirmation ever: the machine requests,
    // waits out the full timeout, retries and requests again.
    task automatic test_long_engage();
        load_settings(65535, 100, 2, 255, 1);
        run_phase(650, 7, 7, 240, 0, 0, 0);
    endtask

    // High rate threshold over a short window with a short timeout, under
    // heavy idling on both sides.
    task automatic test_rate_threshold();
        load_settings(1000, 400, 3, 3, 1);
        run_phase(250, 70, 70, 0, 3, 30, 15);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        reset_model();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_state_walk();
        test_steady_stream();
        test_manual_engage();
        test_unreachable_rate();
        test_long_engage();
        test_rate_threshold();

        // Everything has been sent. Wait for the last statuses, then keep
        // clocking so that the two-stage pipeline can show anything extra.
        drain_results();
        repeat (8)
            @(posedge clk);

        $display("tb: %0d ticks checked under six register settings and five idling mixes",
                 ticks_checked);
        $display("tb: %0d offboard requests, %0d retries and %0d faults were exercised",
                 requests_issued, retries_seen, faults_entered);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Hard stop in case the block hangs on either handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== offboard_handover_supervisor_top.f =====
src/ohs_pkg.sv
src/ohs_cfg_regs.sv
src/ohs_core.sv
src/offboard_handover_supervisor_top.sv
test/tb.sv
